// ----- hdl/slpg_pkg.sv -----
`default_nettype none

package slpg_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_MODE   = 2'd1;
  localparam logic [1:0] OP_PACKET = 2'd2;

  localparam logic [3:0] MODE_STANDBY            = 4'd0;
  localparam logic [3:0] MODE_SEARCH_FOR_WIFI    = 4'd1;
  localparam logic [3:0] MODE_WAIT_FOR_TOUCH     = 4'd2;
  localparam logic [3:0] MODE_SEARCH_FOR_TOUCH   = 4'd3;
  localparam logic [3:0] MODE_SEARCH_WIFI1       = 4'd4;
  localparam logic [3:0] MODE_SEARCH_WIFI2       = 4'd5;
  localparam logic [3:0] MODE_SEARCH_WIFI3       = 4'd6;
  localparam logic [3:0] MODE_WIFI_NO_INTERNET   = 4'd7;
  localparam logic [3:0] MODE_INTERNET_NO_SERVER = 4'd8;
  localparam logic [3:0] MODE_EVERYTHING_OK      = 4'd9;
  localparam logic [3:0] MODE_OTA_IN_PROGRESS    = 4'd10;
  localparam logic [3:0] MODE_WAITING_RESTART    = 4'd11;
  localparam logic [3:0] MODE_INCOMING_PULSE     = 4'd12;

  localparam logic [1:0] LED_NONE  = 2'd0;
  localparam logic [1:0] LED_RED   = 2'd1;
  localparam logic [1:0] LED_GREEN = 2'd2;
  localparam logic [1:0] LED_BOTH  = 2'd3;

  localparam logic [4:0] LIMIT_STEADY    = 5'd0;
  localparam logic [4:0] LIMIT_ALTERNATE = 5'd20;

  // three-flash pattern edges
  localparam logic [7:0] FLASH_ON1  = 8'd4;
  localparam logic [7:0] FLASH_OFF1 = 8'd6;
  localparam logic [7:0] FLASH_ON2  = 8'd10;
  localparam logic [7:0] FLASH_OFF2 = 8'd12;
  localparam logic [7:0] FLASH_END  = 8'd16;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] mode_request;
  } item_t;

  typedef struct packed {
    logic       red_pin;
    logic       green_pin;
    logic [3:0] mode;
  } led_status_t;

endpackage

`default_nettype wire

// ----- hdl/slpg_core.sv -----
`default_nettype none

module slpg_core
  import slpg_pkg::*;
#(
  parameter int PERIOD_TICKS = 20
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire item_t item,
  output led_status_t status_nxt
);

  localparam int PW = $clog2(PERIOD_TICKS);

  logic [PW-1:0] phase_r, phase_nxt;
  logic [3:0]    mode_r, mode_nxt;
  logic [4:0]    limit_r, limit_nxt;
  logic [1:0]    choice_r, choice_nxt;
  logic          red_tog_r, red_tog_nxt;
  logic          green_tog_r, green_tog_nxt;
  logic          flash_r, flash_nxt;
  logic          red_pin_r, red_pin_nxt;
  logic          green_pin_r, green_pin_nxt;

  logic [PW:0]   phase_inc;
  logic [7:0]    phase_ext;

  always_comb begin
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    limit_nxt     = limit_r;
    choice_nxt    = choice_r;
    red_tog_nxt   = red_tog_r;
    green_tog_nxt = green_tog_r;
    flash_nxt     = flash_r;
    red_pin_nxt   = red_pin_r;
    green_pin_nxt = green_pin_r;
    phase_inc     = {1'b0, phase_r} + (PW+1)'(1);
    phase_ext     = 8'(phase_r);

    case (item.operation)
      OP_TICK: begin
        if (phase_inc >= (PW+1)'(PERIOD_TICKS)) begin
          phase_nxt     = '0;
          red_tog_nxt   = 1'b0;
          green_tog_nxt = 1'b0;
        end else begin
          phase_nxt = phase_inc[PW-1:0];
        end
        phase_ext = 8'(phase_nxt);

        case (mode_r)
          MODE_STANDBY: begin
            if (red_tog_nxt) begin
              red_tog_nxt = 1'b0;
              red_pin_nxt = 1'b0;
            end
          end
          MODE_WAIT_FOR_TOUCH:     begin limit_nxt = 5'd2;  choice_nxt = LED_BOTH;  end
          MODE_SEARCH_FOR_TOUCH:   begin limit_nxt = 5'd4;  choice_nxt = LED_BOTH;  end
          MODE_SEARCH_WIFI1:       begin limit_nxt = 5'd2;  choice_nxt = LED_RED;   end
          MODE_SEARCH_WIFI2:       begin limit_nxt = 5'd4;  choice_nxt = LED_RED;   end
          MODE_SEARCH_WIFI3:       begin limit_nxt = 5'd6;  choice_nxt = LED_RED;   end
          MODE_WIFI_NO_INTERNET:   begin limit_nxt = 5'd2;  choice_nxt = LED_GREEN; end
          MODE_INTERNET_NO_SERVER: begin limit_nxt = 5'd4;  choice_nxt = LED_GREEN; end
          MODE_EVERYTHING_OK: begin
            limit_nxt  = LIMIT_STEADY;
            choice_nxt = LED_BOTH;
          end
          MODE_OTA_IN_PROGRESS, MODE_WAITING_RESTART: begin
            limit_nxt  = LIMIT_ALTERNATE;
            choice_nxt = LED_BOTH;
          end
          MODE_INCOMING_PULSE:     begin limit_nxt = 5'd6;  choice_nxt = LED_BOTH;  end
          default: ;
        endcase

        if (limit_nxt == LIMIT_STEADY) begin
          if (flash_r) begin
            if (phase_ext < FLASH_ON1) begin
              red_pin_nxt = 1'b0; green_pin_nxt = 1'b0;
            end else if (phase_ext < FLASH_OFF1) begin
              red_pin_nxt = 1'b1; green_pin_nxt = 1'b1;
            end else if (phase_ext < FLASH_ON2) begin
              red_pin_nxt = 1'b0; green_pin_nxt = 1'b0;
            end else if (phase_ext < FLASH_OFF2) begin
              red_pin_nxt = 1'b1; green_pin_nxt = 1'b1;
            end else if (phase_ext < FLASH_END) begin
              red_pin_nxt = 1'b0; green_pin_nxt = 1'b0;
            end else begin
              red_pin_nxt   = 1'b1;
              green_pin_nxt = 1'b1;
              flash_nxt     = 1'b0;
            end
          end else begin
            red_pin_nxt   = 1'b1;
            green_pin_nxt = 1'b1;
          end
        end else if (limit_nxt == LIMIT_ALTERNATE) begin
          green_tog_nxt = ~green_tog_nxt;
          red_tog_nxt   = ~green_tog_nxt;
          green_pin_nxt = green_tog_nxt;
          red_pin_nxt   = red_tog_nxt;
        end else if (8'(limit_nxt) > phase_ext) begin
          case (choice_nxt)
            LED_RED: begin
              red_tog_nxt   = ~red_tog_nxt;
              red_pin_nxt   = red_tog_nxt;
              green_pin_nxt = 1'b1;
            end
            LED_GREEN: begin
              green_tog_nxt = ~green_tog_nxt;
              green_pin_nxt = green_tog_nxt;
              red_pin_nxt   = 1'b0;
            end
            LED_BOTH: begin
              green_tog_nxt = ~green_tog_nxt;
              red_tog_nxt   = green_tog_nxt;
              green_pin_nxt = green_tog_nxt;
              red_pin_nxt   = green_tog_nxt;
            end
            default: ;
          endcase
        end else begin
          green_pin_nxt = (mode_r inside {MODE_SEARCH_FOR_WIFI, MODE_SEARCH_WIFI1,
                                          MODE_SEARCH_WIFI2, MODE_SEARCH_WIFI3});
          red_pin_nxt   = 1'b0;
        end
      end
      OP_MODE: begin
        if (mode_r != MODE_WAITING_RESTART && item.mode_request <= MODE_INCOMING_PULSE) begin
          mode_nxt = item.mode_request;
        end
      end
      OP_PACKET: begin
        flash_nxt = 1'b1;
      end
      default: ;
    endcase

    status_nxt.red_pin   = red_pin_nxt;
    status_nxt.green_pin = green_pin_nxt;
    status_nxt.mode      = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      mode_r      <= MODE_STANDBY;
      limit_r     <= LIMIT_STEADY;
      choice_r    <= LED_NONE;
      red_tog_r   <= 1'b0;
      green_tog_r <= 1'b0;
      flash_r     <= 1'b0;
      red_pin_r   <= 1'b0;
      green_pin_r <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      limit_r     <= limit_nxt;
      choice_r    <= choice_nxt;
      red_tog_r   <= red_tog_nxt;
      green_tog_r <= green_tog_nxt;
      flash_r     <= flash_nxt;
      red_pin_r   <= red_pin_nxt;
      green_pin_r <= green_pin_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/status_led_pattern_generator.sv -----
// Status LED pattern generator.
// Input channel: in_valid/in_stall carry one word of in_operation (tick,
// mode request, packet notice) and in_mode_request. Every accepted word
// yields exactly one result word on out_valid/out_stall: the red and green
// pin levels after polarity and the mode now held.
// cfg_wr_en/cfg_wr_data write the polarity bit (1 active high, 0 active
// low); write it only while no words are in flight.
// An accepted word passes through the input register, then the state update
// into the result register, before it shows on out_valid.
// Throughput: one word per cycle while out_stall is low; the state update is a
// single pass of logic between the input register and the result register.
// Reset: phase, mode (standby), toggles, flash flag and pins clear, the
// polarity bit reads active low, both pipeline stages empty.
// When out_stall is high the result word holds, the input register keeps its
// word or takes one if empty, and in_stall rises once that register cannot drain.
`default_nettype none

module status_led_pattern_generator
  import slpg_pkg::*;
#(
  parameter int PERIOD_TICKS = 20
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [3:0] in_mode_request,
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       out_red_level,
  output      logic       out_green_level,
  output      logic [3:0] out_mode_now
);

  logic        active_high_r;
  logic        in_valid_r;
  item_t       item_r;
  logic        out_valid_r;
  logic        red_r, green_r;
  logic [3:0]  mode_r;
  logic        adv, accept, step;
  led_status_t status_nxt;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign step     = in_valid_r && adv;

  slpg_core #(
    .PERIOD_TICKS(PERIOD_TICKS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item_r),
    .status_nxt(status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_high_r <= 1'b0;
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_high_r <= cfg_wr_data;
      end
      if (accept) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.operation    <= in_operation;
      item_r.mode_request <= in_mode_request;
    end
    if (step) begin
      red_r   <= status_nxt.red_pin ^ ~active_high_r;
      green_r <= status_nxt.green_pin ^ ~active_high_r;
      mode_r  <= status_nxt.mode;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_mode_now    = mode_r;

endmodule

`default_nettype wire
